// File: rtl/ikf_pkg.sv
// ----------------------------------------------------------------------------
// ikf_pkg
// Shared constants, widths and helpers for the IMU tilt Kalman fusion block.
// ----------------------------------------------------------------------------
package ikf_pkg;

  // algorithm constants
  localparam int CORDIC_STEPS = 18;
  localparam int MAX_DT_MS    = 65535;
  localparam int ANG_MAX      = 11796480;

  // datapath widths
  localparam int ANG_W  = 25;
  localparam int CW     = 34;
  localparam int ZW     = 27;
  localparam int DIV_NW = 44;
  localparam int DIV_DW = 26;

  // atan(2^-i) in Q16 degrees
  function automatic logic [21:0] atan_tab(input logic [4:0] i);
    logic [21:0] v;
    case (i)
      5'd0:    v = 22'd2949120;
      5'd1:    v = 22'd1740967;
      5'd2:    v = 22'd919879;
      5'd3:    v = 22'd466945;
      5'd4:    v = 22'd234379;
      5'd5:    v = 22'd117304;
      5'd6:    v = 22'd58666;
      5'd7:    v = 22'd29335;
      5'd8:    v = 22'd14668;
      5'd9:    v = 22'd7334;
      5'd10:   v = 22'd3667;
      5'd11:   v = 22'd1833;
      5'd12:   v = 22'd917;
      5'd13:   v = 22'd458;
      5'd14:   v = 22'd229;
      5'd15:   v = 22'd115;
      5'd16:   v = 22'd57;
      5'd17:   v = 22'd29;
      5'd18:   v = 22'd14;
      5'd19:   v = 22'd7;
      5'd20:   v = 22'd4;
      5'd21:   v = 22'd2;
      5'd22:   v = 22'd1;
      default: v = 22'd0;
    endcase
    return v;
  endfunction

  // clamp a wide angle to plus or minus 180 degrees
  function automatic logic signed [ANG_W-1:0] sat_ang(input logic signed [47:0] v);
    logic signed [ANG_W-1:0] r;
    if (v > 48'sd11796480) begin
      r = 25'sd11796480;
    end else if (v < -48'sd11796480) begin
      r = -25'sd11796480;
    end else begin
      r = v[ANG_W-1:0];
    end
    return r;
  endfunction

endpackage

// File: rtl/ikf_cordic.sv
// ----------------------------------------------------------------------------
// ikf_cordic
// Iterative CORDIC vectoring unit, one micro-rotation per cycle, gives atan2
// in Q16 degrees saturated to plus or minus 180.
// ----------------------------------------------------------------------------
module ikf_cordic import ikf_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic signed [CW-1:0]    y_in,
  input  logic signed [CW-1:0]    x_in,
  output logic                    done,
  output logic signed [ANG_W-1:0] angle
);

  localparam logic signed [ZW-1:0] Z90 = ZW'(5898240);

  logic signed [CW-1:0] x;
  logic signed [CW-1:0] y;
  logic signed [ZW-1:0] z;
  logic [4:0]           step;
  logic                 busy;
  logic signed [CW-1:0] xs;
  logic signed [CW-1:0] ys;
  logic signed [ZW-1:0] t;

  // shared shifter and angle table lookup
  assign xs = x >>> step;
  assign ys = y >>> step;
  assign t  = $signed({5'b0, atan_tab(step)});

  assign angle = sat_ang({{(48-ZW){z[ZW-1]}}, z});

  // rotation sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
        if (x_in < 0) begin
          if (y_in >= 0) begin
            x <= y_in;
            y <= -x_in;
            z <= Z90;
          end else begin
            x <= -y_in;
            y <= x_in;
            z <= -Z90;
          end
        end else begin
          x <= x_in;
          y <= y_in;
          z <= '0;
        end
      end else if (busy) begin
        if (y > 0) begin
          x <= x + ys;
          y <= y - xs;
          z <= z + t;
        end else begin
          x <= x - ys;
          y <= y + xs;
          z <= z - t;
        end
        step <= step + 5'd1;
        if (step == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/ikf_div.sv
// ----------------------------------------------------------------------------
// ikf_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module ikf_div import ikf_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [DIV_NW-1:0] num,
  input  logic [DIV_DW-1:0] den,
  output logic              done,
  output logic [DIV_NW-1:0] quo
);

  logic [DIV_DW-1:0] rem;
  logic [DIV_DW-1:0] dreg;
  logic [DIV_NW-1:0] q;
  logic [5:0]        cnt;
  logic              busy;
  logic [DIV_DW:0]   sh;
  logic [DIV_DW:0]   diff;
  logic              fits;

  // trial subtract
  assign sh   = {rem, q[DIV_NW-1]};
  assign diff = sh - {1'b0, dreg};
  assign fits = sh >= {1'b0, dreg};
  assign quo  = q;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 6'(DIV_NW);
        rem  <= '0;
        q    <= num;
        dreg <= den;
      end else if (busy) begin
        rem <= fits ? diff[DIV_DW-1:0] : sh[DIV_DW-1:0];
        q   <= {q[DIV_NW-2:0], fits};
        cnt <= cnt - 6'd1;
        if (cnt == 6'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// File: rtl/imu_tilt_kalman_fusion.sv
// ----------------------------------------------------------------------------
// imu_tilt_kalman_fusion
// Accelerometer / gyro tilt fusion with a scalar Kalman gain.
// ----------------------------------------------------------------------------
//  channel  | direction | contents
//  s_*      | in        | one IMU sample per transfer
//  m_*      | out       | fused roll, pitch and gain per sample
//  cfg_*    | in        | noise register writes
//
//  The first sample after reset runs the square root and both CORDIC runs only.
//  Later samples add the gyro prediction, the gain division (skipped on a zero denominator) and the updates.
//  One sample at a time; s_tready is high only while the sequencer is idle.
//  A result waiting in the output register does not hold off the next sample
//  until the sequencer needs to write that register again.
//  Reset is synchronous and restores noise defaults and the filter state.
// ----------------------------------------------------------------------------
module imu_tilt_kalman_fusion import ikf_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // accel_x, accel_y, accel_z, rate_x, rate_y, timestamp_ms
  input  logic [111:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // roll_deg, pitch_deg, gain, zero pad
  output logic [71:0]  m_tdata,
  input  logic         cfg_we,
  input  logic         cfg_index,
  input  logic [23:0]  cfg_data
);

  localparam logic REG_Q = 1'b0;
  localparam logic REG_R = 1'b1;

  // 2^34 / 125 rounded up, exact for dividends below 2^27
  localparam logic [27:0] RECIP_125 = 28'd137438954;

  typedef enum logic [4:0] {
    S_IDLE, S_AY, S_AZ, S_SQI, S_SQRT,
    S_ROLL_GO, S_ROLL_W, S_PITCH_GO, S_PITCH_W,
    S_GX_MUL, S_GX_GO, S_GX_W, S_GX_ADD, S_GY_MUL, S_GY_GO, S_GY_W, S_GY_ADD,
    S_GAIN_GO, S_GAIN_W, S_VAR_MUL, S_VAR,
    S_CR_MUL, S_CR, S_CP_MUL, S_CP, S_OUT
  } state_t;

  state_t state;

  // configuration and filter state
  logic [16:0]              q_noise;
  logic [23:0]              r_noise;
  logic                     started;
  logic signed [ANG_W-1:0]  roll_est;
  logic signed [ANG_W-1:0]  pitch_est;
  logic [24:0]              pvar;
  logic [31:0]              last_time;

  // per-sample registers
  logic signed [15:0]       ax;
  logic signed [15:0]       ay;
  logic signed [15:0]       az;
  logic signed [15:0]       gx;
  logic signed [15:0]       gy;
  logic [15:0]              dt;
  logic [31:0]              sacc;
  logic [61:0]              sv;
  logic [61:0]              sres;
  logic [61:0]              sbit;
  logic [4:0]               scnt;
  logic signed [ANG_W-1:0]  meas_roll;
  logic signed [ANG_W-1:0]  meas_pitch;
  logic signed [ANG_W-1:0]  roll_pred;
  logic signed [ANG_W-1:0]  pitch_pred;
  logic [16:0]              kreg;
  logic signed [44:0]       prod;
  logic [33:0]              gk_hi;
  logic [26:0]              gk_lo;
  logic [33:0]              gdq;

  // shared multiplier operands
  logic signed [26:0]       mul_a;
  logic signed [17:0]       mul_b;

  // unit handshakes
  logic                     cor_start;
  logic signed [CW-1:0]     cor_y;
  logic signed [CW-1:0]     cor_x;
  logic                     cor_done;
  logic signed [ANG_W-1:0]  cor_angle;
  logic                     div_start;
  logic [DIV_NW-1:0]        div_num;
  logic [DIV_DW-1:0]        div_den;
  logic                     div_done;
  logic [DIV_NW-1:0]        div_quo;

  // derived values
  logic [31:0]              d32;
  logic [25:0]              pp_sum;
  logic [24:0]              pp;
  logic [25:0]              den;
  logic [44:0]              pmag;
  logic [61:0]              strial;
  logic [39:0]              gk_n;
  logic [54:0]              gk_prod;
  logic [47:0]              dq;
  logic signed [47:0]       sdelta;
  logic signed [ANG_W-1:0]  gyro_est;
  logic signed [ANG_W-1:0]  gyro_pred;
  logic [41:0]              vsum;
  logic [42:0]              cq_sum;
  logic signed [47:0]       sc;
  logic signed [ANG_W-1:0]  corr_base;
  logic signed [ANG_W-1:0]  corr_new;
  logic signed [25:0]       diff_roll;
  logic signed [25:0]       diff_pitch;

  assign s_tready = (state == S_IDLE);

  // variance prediction and gain denominator
  assign d32    = s_tdata[111:80] - last_time;
  assign pp_sum = {1'b0, pvar} + 26'(q_noise);
  assign pp     = pp_sum[25] ? 25'h1FFFFFF : pp_sum[24:0];
  assign den    = 26'(pp) + 26'(r_noise);

  // magnitude of the last product, shared by gyro and correction steps
  assign pmag   = prod[44] ? 45'(-prod) : 45'(prod);
  assign strial = sres + sbit;

  // gyro increment: round(m * 4096 / 1000) = floor((512m + 62) / 125),
  // split at bit 20 since 2^20 = 125 * 8388 + 76
  assign gk_n    = {pmag[30:0], 9'b0} + 40'd62;
  assign gk_prod = {28'b0, gk_lo} * {27'b0, RECIP_125};

  assign dq        = 48'(gdq);
  assign sdelta    = prod[44] ? -$signed(dq) : $signed(dq);
  assign gyro_est  = (state == S_GY_ADD) ? roll_est : pitch_est;
  assign gyro_pred = sat_ang({{23{gyro_est[24]}}, gyro_est} + sdelta);

  // rounded variance update
  assign vsum = prod[41:0] + 42'd32768;

  // rounded Kalman correction
  assign cq_sum    = pmag[42:0] + 43'd32768;
  assign sc        = prod[44] ? -$signed(48'(cq_sum[42:16])) : $signed(48'(cq_sum[42:16]));
  assign corr_base = (state == S_CR) ? roll_pred : pitch_pred;
  assign corr_new  = sat_ang({{23{corr_base[24]}}, corr_base} + sc);

  assign diff_roll  = {meas_roll[24], meas_roll} - {roll_pred[24], roll_pred};
  assign diff_pitch = {meas_pitch[24], meas_pitch} - {pitch_pred[24], pitch_pred};

  // multiplier operand selection
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_AY: begin
        mul_a = 27'(ay);
        mul_b = 18'(ay);
      end
      S_AZ: begin
        mul_a = 27'(az);
        mul_b = 18'(az);
      end
      S_GX_MUL: begin
        mul_a = 27'(gx);
        mul_b = $signed({2'b0, dt});
      end
      S_GY_MUL: begin
        mul_a = 27'(gy);
        mul_b = $signed({2'b0, dt});
      end
      S_VAR_MUL: begin
        mul_a = $signed({2'b0, pp});
        mul_b = $signed(18'd65536 - {1'b0, kreg});
      end
      S_CR_MUL: begin
        mul_a = 27'(diff_roll);
        mul_b = $signed({1'b0, kreg});
      end
      S_CP_MUL: begin
        mul_a = 27'(diff_pitch);
        mul_b = $signed({1'b0, kreg});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  // CORDIC launch
  assign cor_start = (state == S_ROLL_GO) || (state == S_PITCH_GO);
  assign cor_y = (state == S_ROLL_GO) ? $signed({{4{ay[15]}}, ay, 14'b0})
                                      : $signed({{4{ax[15]}}, ax, 14'b0});
  assign cor_x = (state == S_ROLL_GO) ? $signed({{4{az[15]}}, az, 14'b0})
                                      : $signed({4'b0, sres[29:0]});

  // divider launch, gain only
  assign div_start = (state == S_GAIN_GO) && (den != '0);
  assign div_num   = 44'({pp, 16'h0}) + 44'(den >> 1);
  assign div_den   = den;

  ikf_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cor_start),
    .y_in  (cor_y),
    .x_in  (cor_x),
    .done  (cor_done),
    .angle (cor_angle)
  );

  ikf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  // sequencer, filter state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      q_noise   <= 17'd164;
      r_noise   <= 24'd19661;
      started   <= 1'b0;
      roll_est  <= '0;
      pitch_est <= '0;
      pvar      <= 25'd65536;
      last_time <= '0;
      m_tvalid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_Q:   q_noise <= cfg_data[16:0];
          REG_R:   r_noise <= cfg_data;
          default: ;
        endcase
      end
      if (m_tvalid && m_tready && (state != S_OUT)) begin
        m_tvalid <= 1'b0;
      end
      // product held until the next multiply step
      if (state inside {S_AY, S_AZ, S_GX_MUL, S_GY_MUL, S_VAR_MUL, S_CR_MUL, S_CP_MUL}) begin
        prod <= mul_a * mul_b;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            ax        <= s_tdata[15:0];
            ay        <= s_tdata[31:16];
            az        <= s_tdata[47:32];
            gx        <= s_tdata[63:48];
            gy        <= s_tdata[79:64];
            dt        <= (d32 > 32'(MAX_DT_MS)) ? 16'(MAX_DT_MS) : d32[15:0];
            last_time <= s_tdata[111:80];
            state     <= S_AY;
          end
        end
        S_AY: state <= S_AZ;
        S_AZ: begin
          sacc  <= prod[31:0];
          state <= S_SQI;
        end
        S_SQI: begin
          sv    <= {2'b0, sacc + prod[31:0], 28'h0};
          sres  <= '0;
          sbit  <= 62'(1) << 60;
          scnt  <= '0;
          state <= S_SQRT;
        end
        S_SQRT: begin
          if (sv >= strial) begin
            sv   <= sv - strial;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          scnt <= scnt + 5'd1;
          if (scnt == 5'd30) begin
            state <= S_ROLL_GO;
          end
        end
        S_ROLL_GO: state <= S_ROLL_W;
        S_ROLL_W: begin
          if (cor_done) begin
            meas_roll <= cor_angle;
            state     <= S_PITCH_GO;
          end
        end
        S_PITCH_GO: state <= S_PITCH_W;
        S_PITCH_W: begin
          if (cor_done) begin
            meas_pitch <= -cor_angle;
            if (!started) begin
              started   <= 1'b1;
              roll_est  <= meas_roll;
              pitch_est <= -cor_angle;
              kreg      <= '0;
              state     <= S_OUT;
            end else begin
              state <= S_GX_MUL;
            end
          end
        end
        S_GX_MUL: state <= S_GX_GO;
        S_GX_GO: begin
          gk_hi <= 34'(gk_n[39:20]) * 34'd8388;
          gk_lo <= 27'(gk_n[39:20]) * 27'd76 + 27'(gk_n[19:0]);
          state <= S_GX_W;
        end
        S_GX_W: begin
          gdq   <= gk_hi + 34'(gk_prod[54:34]);
          state <= S_GX_ADD;
        end
        S_GX_ADD: begin
          pitch_pred <= gyro_pred;
          state      <= S_GY_MUL;
        end
        S_GY_MUL: state <= S_GY_GO;
        S_GY_GO: begin
          gk_hi <= 34'(gk_n[39:20]) * 34'd8388;
          gk_lo <= 27'(gk_n[39:20]) * 27'd76 + 27'(gk_n[19:0]);
          state <= S_GY_W;
        end
        S_GY_W: begin
          gdq   <= gk_hi + 34'(gk_prod[54:34]);
          state <= S_GY_ADD;
        end
        S_GY_ADD: begin
          roll_pred <= gyro_pred;
          state     <= S_GAIN_GO;
        end
        S_GAIN_GO: begin
          if (den == '0) begin
            kreg  <= '0;
            state <= S_VAR_MUL;
          end else begin
            state <= S_GAIN_W;
          end
        end
        S_GAIN_W: begin
          if (div_done) begin
            kreg  <= (div_quo > 44'd65536) ? 17'd65536 : div_quo[16:0];
            state <= S_VAR_MUL;
          end
        end
        S_VAR_MUL: state <= S_VAR;
        S_VAR: begin
          pvar  <= vsum[40:16];
          state <= S_CR_MUL;
        end
        S_CR_MUL: state <= S_CR;
        S_CR: begin
          roll_est <= corr_new;
          state    <= S_CP_MUL;
        end
        S_CP_MUL: state <= S_CP;
        S_CP: begin
          pitch_est <= corr_new;
          state     <= S_OUT;
        end
        S_OUT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {5'b0, kreg, pitch_est, roll_est};
            state    <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_one_sample: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("sample accepted while another is in work");

  a_gain_cap: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[66:50] <= 17'd65536)
    else $error("gain above unity");

  a_roll_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[24:0]) <= 25'sd11796480) &&
                 ($signed(m_tdata[24:0]) >= -25'sd11796480))
    else $error("roll outside plus or minus 180");

  a_pitch_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> ($signed(m_tdata[49:25]) <= 25'sd11796480) &&
                 ($signed(m_tdata[49:25]) >= -25'sd11796480))
    else $error("pitch outside plus or minus 180");
`endif

endmodule

// File: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the IMU tilt Kalman fusion block. A queue-fed
// driver sends samples with random gaps. A clocked monitor predicts each
// fused roll, pitch and gain when a sample is accepted, and checks every
// result transfer against the oldest prediction. The run steps through
// several noise settings, including the extremes, and writes them only
// while the block is idle.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_top;
  import ikf_pkg::*;

  typedef enum logic {REG_PROCESS_NOISE = 1'b0, REG_MEAS_NOISE = 1'b1} noise_reg_t;

  typedef struct packed {
    logic signed [15:0] ax, ay, az, gx, gy;
    logic [31:0]        ts;
  } imu_sample_t;

  typedef struct packed {
    logic signed [24:0] roll, pitch;
    logic [16:0]        gain;
  } tilt_out_t;

  localparam longint CYCLE_LIMIT = 2000000;
  localparam int     SETTLE      = 300;

  localparam longint ARC_TAB [24] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1, 0};

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [111:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [71:0]  m_tdata;
  logic         cfg_we = 1'b0;
  logic         cfg_index = 1'b0;
  logic [23:0]  cfg_data = '0;

  imu_sample_t  sample_q [$];
  tilt_out_t    fused_q [$];

  // predictor copy of the filter state and noise registers
  logic         seen_first;
  longint       est_roll, est_pitch, est_var, q_noise, r_noise;
  logic [31:0]  prev_ts;

  int           errors = 0;
  int           n_in = 0, n_out = 0;
  longint       cycles = 0;
  logic         s_fire = 1'b0;
  logic         m_fire = 1'b0;
  int           send_gap = 0, recv_stall = 0;
  logic         gap_on = 1'b1;
  logic [31:0]  ts_next = 0;

  imu_tilt_kalman_fusion u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // clock, 12 ns period
  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic longint clamp180(longint v);
    if (v > ANG_MAX) return ANG_MAX;
    if (v < -ANG_MAX) return -ANG_MAX;
    return v;
  endfunction

  function automatic longint round_div(longint num, longint den);
    longint mag, qt;
    mag = (num < 0) ? -num : num;
    qt  = (mag + den / 2) / den;
    return (num < 0) ? -qt : qt;
  endfunction

  function automatic longint int_sqrt(longint v);
    longint res, bit_v;
    res = 0;
    bit_v = 64'sd1 <<< 62;
    while (bit_v > v) bit_v = bit_v >>> 2;
    while (bit_v != 0) begin
      if (v >= res + bit_v) begin
        v = v - (res + bit_v);
        res = (res >>> 1) + bit_v;
      end else begin
        res = res >>> 1;
      end
      bit_v = bit_v >>> 2;
    end
    return res;
  endfunction

  // cordic vectoring atan2 in Q16 degrees
  function automatic longint arc_deg(longint y, longint x);
    longint z, t, xs, ys;
    z = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; z = 90 * 65536;
      end else begin
        x = -y; y = t; z = -90 * 65536;
      end
    end
    for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ARC_TAB[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ARC_TAB[i];
      end
    end
    return clamp180(z);
  endfunction

  // one filter step on the predictor state
  function automatic tilt_out_t fuse_sample(imu_sample_t s);
    longint ax, ay, az, m_roll, m_pitch, k, dt, pp, den, p_roll, p_pitch;
    tilt_out_t o;
    ax = s.ax; ay = s.ay; az = s.az;
    m_roll  = arc_deg(ay * 16384, az * 16384);
    m_pitch = clamp180(-arc_deg(ax * 16384, int_sqrt((ay * ay + az * az) <<< 28)));
    k = 0;
    if (!seen_first) begin
      seen_first = 1'b1;
      est_roll  = m_roll;
      est_pitch = m_pitch;
    end else begin
      dt = longint'(32'(s.ts - prev_ts));
      if (dt > MAX_DT_MS) dt = MAX_DT_MS;
      p_pitch = clamp180(est_pitch + round_div(longint'(s.gx) * dt * 4096, 1000));
      p_roll  = clamp180(est_roll + round_div(longint'(s.gy) * dt * 4096, 1000));
      pp = est_var + q_noise;
      if (pp > 33554431) pp = 33554431;
      den = pp + r_noise;
      if (den != 0) begin
        k = (pp * 65536 + den / 2) / den;
        if (k > 65536) k = 65536;
      end
      est_var = ((65536 - k) * pp + 32768) >>> 16;
      if (est_var > 33554431) est_var = 33554431;
      est_roll  = clamp180(p_roll + round_div(k * (m_roll - p_roll), 65536));
      est_pitch = clamp180(p_pitch + round_div(k * (m_pitch - p_pitch), 65536));
    end
    prev_ts = s.ts;
    o.roll  = est_roll[24:0];
    o.pitch = est_pitch[24:0];
    o.gain  = k[16:0];
    return o;
  endfunction

  // sender: one sample held until its transfer, random gap before each
  always @(negedge clk) begin
    if (!rst && (!s_tvalid || s_fire)) begin
      if (send_gap > 0) begin
        send_gap <= send_gap - 1;
        s_tvalid <= 1'b0;
      end else if (sample_q.size() > 0) begin
        s_tdata  <= {sample_q[0].ts, sample_q[0].gy, sample_q[0].gx,
                     sample_q[0].az, sample_q[0].ay, sample_q[0].ax};
        s_tvalid <= 1'b1;
        void'(sample_q.pop_front());
        send_gap <= gap_on ? $urandom_range(0, 5) : 0;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // receiver: random stall before accepting each result
  always @(negedge clk) begin
    int stall_draw;
    if (rst) begin
      m_tready <= 1'b0;
    end else if (m_fire) begin
      stall_draw = gap_on ? $urandom_range(0, 5) : 0;
      if (stall_draw > 0) begin
        recv_stall <= stall_draw - 1;
        m_tready   <= 1'b0;
      end else begin
        m_tready <= 1'b1;
      end
    end else if (recv_stall > 0) begin
      recv_stall <= recv_stall - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // monitor: predict on sample transfer, check on result transfer
  always @(posedge clk) begin
    tilt_out_t want, got;
    imu_sample_t smp;
    cycles <= cycles + 1;
    s_fire <= s_tvalid && s_tready && !rst;
    m_fire <= m_tvalid && m_tready && !rst;
    if (!rst && s_tvalid && s_tready) begin
      smp = {s_tdata[15:0], s_tdata[31:16], s_tdata[47:32], s_tdata[63:48],
             s_tdata[79:64], s_tdata[111:80]};
      fused_q.push_back(fuse_sample(smp));
      n_in++;
    end
    if (!rst && m_tvalid && m_tready) begin
      got.roll  = m_tdata[24:0];
      got.pitch = m_tdata[49:25];
      got.gain  = m_tdata[66:50];
      n_out++;
      if (fused_q.size() == 0) begin
        $display("%0t: result with nothing expected: roll %0d pitch %0d gain %0d",
                 $time, got.roll, got.pitch, got.gain);
        errors++;
      end else begin
        want = fused_q.pop_front();
        if (got.roll !== want.roll) begin
          $display("%0t: roll expected %0d actual %0d", $time, want.roll, got.roll);
          errors++;
        end
        if (got.pitch !== want.pitch) begin
          $display("%0t: pitch expected %0d actual %0d", $time, want.pitch, got.pitch);
          errors++;
        end
        if (got.gain !== want.gain) begin
          $display("%0t: gain expected %0d actual %0d", $time, want.gain, got.gain);
          errors++;
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, fused_q.size());
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic push_sample(int ax, int ay, int az, int gx, int gy, logic [31:0] ts);
    imu_sample_t s;
    s.ax = 16'(ax); s.ay = 16'(ay); s.az = 16'(az); s.gx = 16'(gx); s.gy = 16'(gy);
    s.ts = ts;
    sample_q.push_back(s);
  endtask

  // mostly plausible motion, some raw noise
  task automatic push_random(int n);
    int g;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 9) < 2) begin
        push_sample($urandom, $urandom, $urandom, $urandom, $urandom, $urandom);
      end else begin
        g = $urandom_range(0, 3) == 0 ? 32767 : 16384;
        ts_next = ts_next + $urandom_range(0, 25);
        push_sample($urandom_range(0, 2 * g) - g, $urandom_range(0, 2 * g) - g,
                    $urandom_range(0, 2 * g) - g, $urandom_range(0, 4000) - 2000,
                    $urandom_range(0, 4000) - 2000, ts_next);
      end
    end
  endtask

  // noise write, only while idle
  task automatic write_noise(noise_reg_t idx, logic [23:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    if (idx == REG_PROCESS_NOISE) q_noise = longint'(val[16:0]);
    else r_noise = longint'(val);
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain;
    while (sample_q.size() > 0 || s_tvalid || fused_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  initial begin
    seen_first = 1'b0;
    est_roll = 0; est_pitch = 0; est_var = 65536;
    q_noise = 164; r_noise = 19661; prev_ts = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes, zero vector, timestamp wrap and reversal
    push_sample(0, 0, 16384, 0, 0, 32'd10);
    push_sample(-32768, -32768, -32768, -32768, -32768, 32'd20);
    push_sample(32767, 32767, 32767, 32767, 32767, 32'd30);
    push_sample(0, 0, 0, 0, 0, 32'd30);
    push_sample(32767, 0, 0, 100, -100, 32'd31);
    push_sample(-32768, 0, 0, -100, 100, 32'd32);
    push_sample(0, 32767, -32768, 0, 0, 32'd40);
    push_sample(0, -32768, -1, 0, 0, 32'd50);
    push_sample(0, 1, -32768, 32767, -32768, 32'd5);
    push_sample(100, -200, 16000, 16, -16, 32'hFFFF_FFF0);
    push_sample(100, -200, 16000, 16, -16, 32'h0000_0010);
    push_sample(-5, 7, -16000, 32767, 32767, 32'h0001_0010);
    push_sample(0, 0, 16384, -32768, -32768, 32'h0002_0020);
    push_sample(0, -1, 0, 1, -1, 32'h0002_0021);
    push_sample(1, 0, -1, 0, 0, 32'h0002_0022);
    ts_next = 32'h0002_0022;
    drain();

    write_noise(REG_PROCESS_NOISE, 24'd0);
    write_noise(REG_MEAS_NOISE, 24'd1);
    push_random(110);
    drain();

    write_noise(REG_PROCESS_NOISE, 24'd65536);
    write_noise(REG_MEAS_NOISE, 24'd16777215);
    gap_on = 1'b0;
    push_random(110);
    drain();

    gap_on = 1'b1;
    write_noise(REG_PROCESS_NOISE, 24'd131071);
    write_noise(REG_MEAS_NOISE, 24'd0);
    push_random(110);
    drain();

    // zero gain denominator once the variance collapses
    write_noise(REG_PROCESS_NOISE, 24'd0);
    write_noise(REG_MEAS_NOISE, 24'd0);
    push_random(80);
    drain();

    write_noise(REG_PROCESS_NOISE, 24'd0);
    write_noise(REG_MEAS_NOISE, 24'd16777215);
    push_random(80);
    drain();

    write_noise(REG_PROCESS_NOISE, 24'($urandom_range(0, 65536)));
    write_noise(REG_MEAS_NOISE, 24'($urandom_range(1, 200000)));
    push_random(200);
    drain();

    $display("covered %0d samples and %0d results over seven noise settings", n_in, n_out);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("%0d mismatches", errors);
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
